@@ rtl/bfa_pkg.sv @@
// shared types and constants of the best-fit arena allocator
`default_nettype none
package bfa_pkg;

	localparam int LEN_W        = 13;
	localparam int HEADER_BYTES = 16;
	localparam int ARENA_MAX    = 4096;
	localparam int ARENA_RESET  = 4096;
	localparam int ARENA_LOW    = (32 > HEADER_BYTES + 1) ? 32 : HEADER_BYTES + 1;

	localparam logic [LEN_W-1:0] HDR       = LEN_W'(HEADER_BYTES);
	localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'(ARENA_RESET - HEADER_BYTES);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(ARENA_MAX);
	localparam logic [LEN_W-1:0] LEN_LOW   = LEN_W'(ARENA_LOW);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_DOUBLE  = 2'd2,
		ST_BADADDR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REWR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic             kind;
		logic [LEN_W-1:0] req_size;
		logic [LEN_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] addr;
	} rsp_t;

	// one segment table entry held in a cell
	typedef struct packed {
		logic             valid;
		logic             free;
		logic [LEN_W-1:0] len;
	} seg_t;

	typedef struct packed {
		logic             shift;
		logic             init;
		logic [LEN_W-1:0] init_len;
	} ring_ctl_t;

endpackage
`default_nettype wire

@@ rtl/best_fit_arena_allocator_top.sv @@
// top level: best-fit arena allocator built as a ring of segment cells
`default_nettype none
// a request runs a scan pass over the cell ring, then a rewrite pass if it changes the table,
// then the result state; one that fails (no fit, bad address, already free) skips the rewrite pass
// a new request is taken only once the block is back in idle; done is high for exactly one cycle
// reset: the table holds one free segment spanning the 4096-byte arena, count one; no stall input
// a configuration write reinitialises the table while idle
module best_fit_arena_allocator_top #(
	parameter int MAX_SEGMENTS = 256
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire bfa_pkg::req_t             req,
	output logic                           done,
	output bfa_pkg::rsp_t                  rsp,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [bfa_pkg::LEN_W-1:0] cfg_data
);

	// ring of cells: each cycle of a pass every entry moves one cell towards
	// the head, the head entry is inspected and the rewritten entry enters at the tail
	bfa_pkg::seg_t      seg [MAX_SEGMENTS];
	bfa_pkg::seg_t      tail;
	bfa_pkg::ring_ctl_t ctl;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
			if (gi == MAX_SEGMENTS - 1) begin : g_last
				bfa_cell #(.HEAD(gi == 0)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.ctl    (ctl),
					.nxt    (tail),
					.seg    (seg[gi])
				);
			end else begin : g_mid
				bfa_cell #(.HEAD(gi == 0)) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.ctl    (ctl),
					.nxt    (seg[gi+1]),
					.seg    (seg[gi])
				);
			end
		end
	endgenerate

	// sequencer looks at the head and the two entries behind it, which is
	// enough to fold a freed segment with both free neighbours in one step
	bfa_ctrl #(.N_SEG(MAX_SEGMENTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.c0        (seg[0]),
		.c1        (seg[1]),
		.c2        (seg[2]),
		.ctl       (ctl),
		.tail      (tail)
	);

endmodule
`default_nettype wire

@@ rtl/bfa_cell.sv @@
// one cell of the segment ring: holds one table entry
`default_nettype none
module bfa_cell #(
	parameter bit HEAD = 1'b0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bfa_pkg::ring_ctl_t ctl,
	input  wire bfa_pkg::seg_t     nxt,
	output bfa_pkg::seg_t          seg
);

	bfa_pkg::seg_t seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q.valid <= HEAD;
			seg_q.free  <= HEAD;
			seg_q.len   <= HEAD ? bfa_pkg::RESET_LEN : '0;
		end else if (ctl.init) begin
			seg_q.valid <= HEAD;
			seg_q.free  <= HEAD;
			seg_q.len   <= HEAD ? ctl.init_len : '0;
		end else if (ctl.shift) begin
			seg_q <= nxt;
		end
	end

	assign seg = seg_q;

endmodule
`default_nettype wire

@@ rtl/bfa_ctrl.sv @@
// sequencer: scan pass and rewrite pass over the segment ring
`default_nettype none
module bfa_ctrl #(
	parameter int N_SEG = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire bfa_pkg::req_t      req,
	output logic                    done,
	output bfa_pkg::rsp_t           rsp,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [bfa_pkg::LEN_W-1:0] cfg_data,
	input  wire bfa_pkg::seg_t      c0,
	input  wire bfa_pkg::seg_t      c1,
	input  wire bfa_pkg::seg_t      c2,
	output bfa_pkg::ring_ctl_t      ctl,
	output bfa_pkg::seg_t           tail
);

	localparam int IW = $clog2(N_SEG);
	localparam int CW = $clog2(N_SEG + 1);
	localparam int KW = CW + 1;
	localparam int LW = bfa_pkg::LEN_W;

	bfa_pkg::state_t state_q, state_d;
	bfa_pkg::req_t   req_q;
	bfa_pkg::rsp_t   rsp_q;
	bfa_pkg::seg_t   d_q;
	logic [IW-1:0]   k_q, pick_q, hit_q;
	logic [CW-1:0]   cnt_q;
	logic [LW-1:0]   best_q, pstart_q, run_q;
	logic            found_q, hfree_q, lag_q, merged_q;
	logic [1:0]      r_q;

	logic [KW-1:0] k_ext, k_p1, k_p2, k_pr;
	logic          last, fit, upd_alloc, upd_free, split;
	logic [LW-1:0] surplus;
	logic          nx_prev, nx_hit, at_prev, at_hit;
	logic [LW-1:0] len_prev, len_hit;
	bfa_pkg::seg_t src;
	logic [LW-1:0] clamp;

	assign k_ext = KW'(k_q);
	assign k_p1  = k_ext + KW'(1);
	assign k_p2  = k_ext + KW'(2);
	assign k_pr  = k_ext + KW'(r_q);
	assign last  = (k_q == IW'(N_SEG - 1));

	// allocate scan: best fit, later entry wins ties
	assign surplus   = c0.len - req_q.req_size;
	assign fit       = c0.valid && c0.free && (c0.len >= req_q.req_size);
	assign upd_alloc = fit && (!found_q || (surplus <= best_q));
	// free scan: first entry whose payload starts at the offset
	assign upd_free  = !found_q && c0.valid
		&& ((run_q + bfa_pkg::HDR) == req_q.free_addr);

	assign split = (best_q > bfa_pkg::HDR) && (cnt_q < CW'(N_SEG));

	// merge group starting at the free predecessor or at the freed entry
	assign at_prev  = !merged_q && (k_p1 == KW'(hit_q)) && c0.valid && c0.free;
	assign at_hit   = !merged_q && (k_q == hit_q);
	assign nx_prev  = c2.valid && c2.free && (k_p2 < KW'(N_SEG));
	assign nx_hit   = c1.valid && c1.free && (k_p1 < KW'(N_SEG));
	assign len_prev = c0.len + bfa_pkg::HDR + c1.len
		+ (nx_prev ? (bfa_pkg::HDR + c2.len) : '0);
	assign len_hit  = c0.len + (nx_hit ? (bfa_pkg::HDR + c1.len) : '0);

	always_comb begin
		case (r_q)
			2'd1:    src = c1;
			2'd2:    src = c2;
			default: src = c0;
		endcase
	end

	always_comb begin
		if (cfg_data < bfa_pkg::LEN_LOW) begin
			clamp = bfa_pkg::LEN_LOW;
		end else if (cfg_data > bfa_pkg::LEN_MAX) begin
			clamp = bfa_pkg::LEN_MAX;
		end else begin
			clamp = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl.shift    = 1'b0;
		ctl.init     = 1'b0;
		ctl.init_len = clamp - bfa_pkg::HDR;
		tail         = c0;
		busy         = (state_q != bfa_pkg::S_IDLE);
		cfg_ready    = (state_q == bfa_pkg::S_IDLE);
		done         = (state_q == bfa_pkg::S_RESP);
		case (state_q)
			bfa_pkg::S_IDLE: begin
				ctl.init = cfg_valid;
				if (start) begin
					state_d = bfa_pkg::S_SCAN;
				end
			end
			bfa_pkg::S_SCAN: begin
				ctl.shift = 1'b1;
				if (last) begin
					if (req_q.kind == bfa_pkg::KIND_ALLOC) begin
						state_d = (found_q || upd_alloc) ? bfa_pkg::S_REWR
							: bfa_pkg::S_RESP;
					end else if (upd_free) begin
						state_d = c0.free ? bfa_pkg::S_RESP : bfa_pkg::S_REWR;
					end else if (found_q) begin
						state_d = hfree_q ? bfa_pkg::S_RESP : bfa_pkg::S_REWR;
					end else begin
						state_d = bfa_pkg::S_RESP;
					end
				end
			end
			bfa_pkg::S_REWR: begin
				ctl.shift = 1'b1;
				if (req_q.kind == bfa_pkg::KIND_ALLOC) begin
					if (k_q == pick_q) begin
						tail = '{valid: 1'b1, free: 1'b0,
							len: split ? req_q.req_size : c0.len};
					end else if (lag_q) begin
						tail = d_q;
					end
				end else begin
					if (at_prev) begin
						tail = '{valid: 1'b1, free: 1'b1, len: len_prev};
					end else if (at_hit) begin
						tail = '{valid: 1'b1, free: 1'b1, len: len_hit};
					end else if (merged_q) begin
						tail = (k_pr < KW'(N_SEG)) ? src : '0;
					end
				end
				if (last) begin
					state_d = bfa_pkg::S_RESP;
				end
			end
			bfa_pkg::S_RESP: begin
				state_d = bfa_pkg::S_IDLE;
			end
			default: begin
				state_d = bfa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= CW'(1);
			k_q      <= '0;
			found_q  <= 1'b0;
			lag_q    <= 1'b0;
			merged_q <= 1'b0;
			r_q      <= '0;
		end else begin
			case (state_q)
				bfa_pkg::S_IDLE: begin
					if (cfg_valid) begin
						cnt_q <= CW'(1);
					end
					k_q      <= '0;
					found_q  <= 1'b0;
					lag_q    <= 1'b0;
					merged_q <= 1'b0;
					r_q      <= '0;
				end
				bfa_pkg::S_SCAN: begin
					k_q <= last ? '0 : k_q + IW'(1);
					if (req_q.kind == bfa_pkg::KIND_ALLOC) begin
						if (upd_alloc) begin
							found_q <= 1'b1;
						end
					end else if (upd_free) begin
						found_q <= 1'b1;
					end
				end
				bfa_pkg::S_REWR: begin
					k_q <= last ? '0 : k_q + IW'(1);
					if (req_q.kind == bfa_pkg::KIND_ALLOC) begin
						if (k_q == pick_q && split) begin
							lag_q <= 1'b1;
						end
						if (last && split) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end else begin
						if (at_prev) begin
							merged_q <= 1'b1;
							r_q      <= nx_prev ? 2'd2 : 2'd1;
							cnt_q    <= cnt_q - (nx_prev ? CW'(2) : CW'(1));
						end else if (at_hit) begin
							merged_q <= 1'b1;
							r_q      <= nx_hit ? 2'd1 : 2'd0;
							cnt_q    <= cnt_q - (nx_hit ? CW'(1) : CW'(0));
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			bfa_pkg::S_IDLE: begin
				req_q <= req;
				run_q <= '0;
			end
			bfa_pkg::S_SCAN: begin
				if (c0.valid) begin
					run_q <= run_q + bfa_pkg::HDR + c0.len;
				end
				if (req_q.kind == bfa_pkg::KIND_ALLOC) begin
					if (upd_alloc) begin
						best_q   <= surplus;
						pick_q   <= k_q;
						pstart_q <= run_q;
					end
					rsp_q.status <= bfa_pkg::ST_NOFIT;
				end else begin
					if (upd_free) begin
						hit_q   <= k_q;
						hfree_q <= c0.free;
					end
					if (upd_free) begin
						rsp_q.status <= c0.free ? bfa_pkg::ST_DOUBLE : bfa_pkg::ST_OK;
					end else if (!found_q) begin
						rsp_q.status <= bfa_pkg::ST_BADADDR;
					end
				end
				rsp_q.addr <= '0;
			end
			bfa_pkg::S_REWR: begin
				if (req_q.kind == bfa_pkg::KIND_ALLOC) begin
					if (k_q == pick_q) begin
						d_q <= '{valid: 1'b1, free: 1'b1, len: best_q - bfa_pkg::HDR};
					end else if (lag_q) begin
						d_q <= c0;
					end
					rsp_q.status <= bfa_pkg::ST_OK;
					rsp_q.addr   <= pstart_q + bfa_pkg::HDR;
				end else begin
					rsp_q.status <= bfa_pkg::ST_OK;
					rsp_q.addr   <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp = rsp_q;

`ifndef SYNTH
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != bfa_pkg::ST_OK) |-> (rsp.addr == '0))
		else $error("address driven on a failed request");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken without going busy");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= CW'(N_SEG)))
		else $error("segment count out of range");
`endif

endmodule
`default_nettype wire

@@ dv/bfa_checker.sv @@
// checker for the best-fit arena allocator: models the segment table and compares results
`timescale 1ns / 1ps
`default_nettype none
module bfa_checker #(
	parameter int MAX_SEGMENTS = 256
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      busy,
	input  wire bfa_pkg::req_t             req,
	input  wire logic                      done,
	input  wire bfa_pkg::rsp_t             rsp,
	input  wire logic                      cfg_valid,
	input  wire logic                      cfg_ready,
	input  wire logic [bfa_pkg::LEN_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending
);

	int unsigned   seg_len [MAX_SEGMENTS];
	bit            seg_free[MAX_SEGMENTS];
	int unsigned   n_segs;
	bfa_pkg::rsp_t rsp_queue[$];

	assign pending = rsp_queue.size();

	function automatic void arena_init(input int unsigned size);
		if (size < bfa_pkg::ARENA_LOW) size = bfa_pkg::ARENA_LOW;
		if (size > bfa_pkg::ARENA_MAX) size = bfa_pkg::ARENA_MAX;
		seg_len[0]  = size - bfa_pkg::HEADER_BYTES;
		seg_free[0] = 1'b1;
		n_segs      = 1;
	endfunction

	function automatic bfa_pkg::rsp_t arena_step(input bfa_pkg::req_t r);
		bfa_pkg::rsp_t o;
		bit            found;
		int unsigned   best, pick, pos, pick_pos, hit;
		o.status = bfa_pkg::ST_OK;
		o.addr   = '0;
		found    = 0;
		best     = 0;
		pick     = 0;
		pos      = 0;
		pick_pos = 0;
		hit      = 0;
		if (r.kind == bfa_pkg::KIND_ALLOC) begin
			for (int i = 0; i < n_segs; i++) begin
				if (seg_free[i] && seg_len[i] >= r.req_size &&
				    (!found || seg_len[i] - r.req_size <= best)) begin
					found    = 1;
					best     = seg_len[i] - r.req_size;
					pick     = i;
					pick_pos = pos;
				end
				pos += bfa_pkg::HEADER_BYTES + seg_len[i];
			end
			if (!found) o.status = bfa_pkg::ST_NOFIT;
			else begin
				// split only if the remainder can carry a header and a byte
				if (best > bfa_pkg::HEADER_BYTES && n_segs < MAX_SEGMENTS) begin
					for (int j = n_segs; j > pick + 1; j--) begin
						seg_len[j]  = seg_len[j-1];
						seg_free[j] = seg_free[j-1];
					end
					seg_len[pick+1]  = best - bfa_pkg::HEADER_BYTES;
					seg_free[pick+1] = 1'b1;
					n_segs++;
					seg_len[pick] = r.req_size;
				end
				seg_free[pick] = 1'b0;
				o.addr = bfa_pkg::LEN_W'(pick_pos + bfa_pkg::HEADER_BYTES);
			end
		end else begin
			for (int i = 0; i < n_segs; i++) begin
				if (!found && pos + bfa_pkg::HEADER_BYTES == r.free_addr) begin
					found = 1;
					hit   = i;
				end
				pos += bfa_pkg::HEADER_BYTES + seg_len[i];
			end
			if (!found) o.status = bfa_pkg::ST_BADADDR;
			else if (seg_free[hit]) o.status = bfa_pkg::ST_DOUBLE;
			else begin
				int unsigned k;
				seg_free[hit] = 1'b1;
				k = 0;
				while (k + 1 < n_segs) begin
					if (seg_free[k] && seg_free[k+1]) begin
						seg_len[k] += bfa_pkg::HEADER_BYTES + seg_len[k+1];
						for (int j = k + 1; j < n_segs - 1; j++) begin
							seg_len[j]  = seg_len[j+1];
							seg_free[j] = seg_free[j+1];
						end
						n_segs--;
					end else k++;
				end
			end
		end
		return o;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			fail_count = 0;
			rsp_queue.delete();
			arena_init(bfa_pkg::ARENA_RESET);
		end else begin
			if (done) begin
				if (rsp_queue.size() == 0) begin
					$display("%0t: unexpected result status=%0d addr=%0d", $time,
						rsp.status, rsp.addr);
					fail_count++;
				end else begin
					bfa_pkg::rsp_t want;
					want = rsp_queue.pop_front();
					if (want.status !== rsp.status)  begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, rsp.status);
						fail_count++;
					end
					if (want.addr !== rsp.addr) begin
						$display("%0t: addr expected %0d actual %0d", $time,
							want.addr, rsp.addr);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) arena_init(cfg_data);
			if (start && !busy) rsp_queue.push_back(arena_step(req));
		end
	end
endmodule
`default_nettype wire

@@ dv/tb_best_fit_arena_allocator_top.sv @@
// testbench top: stimulus for the best-fit arena allocator and the final verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_best_fit_arena_allocator_top;

	localparam int SEGS        = 256;
	localparam int SETTLE      = 2 * SEGS + 10;
	localparam int STALL_LIMIT = 20000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	bfa_pkg::req_t             req = '0;
	logic                      done;
	bfa_pkg::rsp_t             rsp;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [bfa_pkg::LEN_W-1:0] cfg_data = '0;
	int                        fail_count;
	int                        pending;
	int                        quiet_cycles = 0;
	int                        idle_pct = 0;
	// payload offsets handed out and not yet released
	logic [bfa_pkg::LEN_W-1:0] live_addrs[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	best_fit_arena_allocator_top #(.MAX_SEGMENTS(SEGS)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	bfa_checker #(.MAX_SEGMENTS(SEGS)) i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	// watchdog on cycles without any accepted request, result or write
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// remember granted offsets so frees can hit real segments
	always @(posedge clk) begin
		if (done && rsp.status == bfa_pkg::ST_OK && rsp.addr != 0)
			live_addrs.push_back(rsp.addr);
	end

	task automatic send_request(input logic kind, input int unsigned size,
		input int unsigned faddr);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
		req.kind      <= kind;
		req.req_size  <= bfa_pkg::LEN_W'(size);
		req.free_addr <= bfa_pkg::LEN_W'(faddr);
		start         <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		start <= 1'b0;
		// the block stays busy for long after this, so the spare wait costs nothing
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_arena(input int unsigned bytes);
		wait_drained();
		live_addrs.delete();
		cfg_data  <= bfa_pkg::LEN_W'(bytes);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// free a live offset, mostly real, sometimes double or bogus
	task automatic free_something();
		int unsigned pick;
		if (live_addrs.size() != 0 && $urandom_range(9) < 8) begin
			pick = $urandom_range(live_addrs.size() - 1);
			send_request(bfa_pkg::KIND_FREE, $urandom, live_addrs[pick]);
			if ($urandom_range(9) != 0) live_addrs.delete(pick);
		end else
			send_request(bfa_pkg::KIND_FREE, $urandom, $urandom_range(8191));
	endtask

	task automatic random_phase(input int count, input int pct, input int max_size);
		idle_pct = pct;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 55)
				send_request(bfa_pkg::KIND_ALLOC,
					$urandom_range(9) == 0 ? $urandom_range(8191)
					: $urandom_range(max_size), $urandom);
			else free_something();
		end
		idle_pct = 0;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset arena, extremes, zero size, exact fit, no fit, frees
		send_request(bfa_pkg::KIND_ALLOC, 0, 0);
		send_request(bfa_pkg::KIND_ALLOC, 8191, 8191);
		send_request(bfa_pkg::KIND_ALLOC, 4096, 0);
		send_request(bfa_pkg::KIND_ALLOC, 100, 0);
		send_request(bfa_pkg::KIND_ALLOC, 17, 0);
		send_request(bfa_pkg::KIND_FREE, 0, 16);
		send_request(bfa_pkg::KIND_FREE, 0, 16);
		send_request(bfa_pkg::KIND_FREE, 0, 8191);
		send_request(bfa_pkg::KIND_FREE, 0, 17);
		send_request(bfa_pkg::KIND_FREE, 0, 32);
		send_request(bfa_pkg::KIND_FREE, 0, 148);
		write_arena(0);
		send_request(bfa_pkg::KIND_ALLOC, 16, 0);
		send_request(bfa_pkg::KIND_ALLOC, 0, 0);
		send_request(bfa_pkg::KIND_FREE, 0, 16);
		write_arena(8191);
		send_request(bfa_pkg::KIND_ALLOC, 4080, 0);
		send_request(bfa_pkg::KIND_FREE, 0, 16);
		write_arena(4096);

		// table-full path: many zero-size allocates
		for (int n = 0; n < 260; n++) send_request(bfa_pkg::KIND_ALLOC, 0, 0);
		write_arena(300);
		random_phase(150, 0, 40);
		write_arena(4096);
		random_phase(250, 0, 200);
		wait_drained();
		random_phase(200, 77, 300);
		write_arena(1000);
		random_phase(200, 77, 120);
		write_arena(32);
		random_phase(40, 7, 20);
		write_arena(4096);
		random_phase(300, 7, 400);

		wait_drained();
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
